// ----- rtl/bpa_pkg.sv -----
// Package for the bitmap page allocator: request/response payloads,
// controller-to-datapath command and status structs, and shared helpers.
// No dependencies.
`default_nettype none

package bpa_pkg;

  // Fixed field widths
  localparam int unsigned ADDR_W    = 41;
  localparam int unsigned FUNC_W    = 2;
  localparam int unsigned WORD_BITS = 32;
  localparam int unsigned IDX_W     = 5;   // bit index within a 32-bit word

  // Request codes
  typedef enum logic [FUNC_W-1:0] {
    FUNC_ALLOC = 2'd0,
    FUNC_FREE  = 2'd1,
    FUNC_MARK  = 2'd2,
    FUNC_NOP   = 2'd3
  } func_e;

  // What goes into the response register
  typedef enum logic [1:0] {
    RES_NONE,
    RES_PAGE,
    RES_OOR
  } res_sel_e;

  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [ADDR_W-1:0] address;
  } alloc_req_t;

  typedef struct packed {
    logic [ADDR_W-1:0] page_address;
    logic              found;
    logic              out_of_range;
  } alloc_rsp_t;

  // Controller -> datapath
  typedef struct packed {
    logic     cap_req;     // capture request address
    logic     scan_start;  // allocate: start summary scan at chunk 0
    logic     scan_next;   // step to next top-level chunk
    logic     alloc_l3;    // pick L2 word from top chunk, read L2
    logic     alloc_l2;    // pick L1 word from L2 data, read L1
    logic     alloc_l1;    // pick map word from L1 data, read map
    logic     alloc_l0;    // pick page bit from map data
    logic     rd_all;      // free/mark: read all three levels at once
    logic     gate;        // free/mark: qualify read data with summaries
    logic     update;      // write back map word and summaries
    logic     set_bit;     // update sets the page bit, else clears it
    logic     res_load;    // load response register
    res_sel_e res_sel;
  } dp_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic chunk_nz;    // current top chunk has a non-empty L2 word
    logic chunk_last;  // current top chunk is the last one
    logic oor;         // captured address lies beyond the map
  } dp_sts_t;

  // Index of the lowest set bit, zero for an empty word
  function automatic logic [IDX_W-1:0] find_first(logic [WORD_BITS-1:0] w);
    logic [IDX_W-1:0] idx;
    idx = '0;
    for (int i = WORD_BITS - 1; i >= 0; i--) begin
      if (w[i]) idx = IDX_W'(i);
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/bpa_ctrl.sv -----
// Controller for the bitmap page allocator: sequences one request at a time
// through the datapath and owns the response handshake. Uses bpa_pkg.
`default_nettype none

module bpa_ctrl
  import bpa_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              req_valid_i,
  output logic                   req_ready_o,
  input  wire logic [FUNC_W-1:0] req_func_i,
  output logic                   rsp_valid_o,
  input  wire logic              rsp_ready_i,
  output dp_cmd_t                cmd_o,
  input  wire dp_sts_t           sts_i
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,
    S_L2,
    S_L1,
    S_L0,
    S_RD,
    S_GATE,
    S_UPD,
    S_DONE
  } state_e;

  state_e            state_q;
  logic [FUNC_W-1:0] func_q;
  res_sel_e          res_sel_q;
  logic              rsp_valid_q;

  assign req_ready_o = (state_q == S_IDLE);
  assign rsp_valid_o = rsp_valid_q;

  // Commands for the current step
  always_comb begin
    cmd_o         = '0;
    cmd_o.set_bit = (func_q == FUNC_FREE);
    cmd_o.res_sel = res_sel_q;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.cap_req    = req_valid_i;
        cmd_o.scan_start = (req_func_i == FUNC_ALLOC);
      end
      S_SCAN: begin
        if (sts_i.chunk_nz) begin
          cmd_o.alloc_l3 = 1'b1;
        end else if (!sts_i.chunk_last) begin
          cmd_o.scan_next = 1'b1;
        end
      end
      S_L2:   cmd_o.alloc_l2 = 1'b1;
      S_L1:   cmd_o.alloc_l1 = 1'b1;
      S_L0:   cmd_o.alloc_l0 = 1'b1;
      S_RD:   cmd_o.rd_all   = !sts_i.oor;
      S_GATE: cmd_o.gate     = 1'b1;
      S_UPD:  cmd_o.update   = 1'b1;
      S_DONE: cmd_o.res_load = !rsp_valid_q || rsp_ready_i;
      default: ;
    endcase
  end

  // State and registered outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      func_q      <= FUNC_NOP;
      res_sel_q   <= RES_NONE;
      rsp_valid_q <= 1'b0;
    end else begin
      if (cmd_o.res_load) begin
        rsp_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        rsp_valid_q <= 1'b0;
      end

      unique case (state_q)
        S_IDLE: begin
          if (req_valid_i) begin
            func_q <= req_func_i;
            unique case (req_func_i)
              FUNC_ALLOC: state_q <= S_SCAN;
              FUNC_FREE,
              FUNC_MARK:  state_q <= S_RD;
              default: begin
                res_sel_q <= RES_NONE;
                state_q   <= S_DONE;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (sts_i.chunk_nz) begin
            res_sel_q <= RES_PAGE;
            state_q   <= S_L2;
          end else if (sts_i.chunk_last) begin
            // map full
            res_sel_q <= RES_NONE;
            state_q   <= S_DONE;
          end
        end
        S_L2: state_q <= S_L1;
        S_L1: state_q <= S_L0;
        S_L0: state_q <= S_UPD;
        S_RD: begin
          if (sts_i.oor) begin
            res_sel_q <= RES_OOR;
            state_q   <= S_DONE;
          end else begin
            res_sel_q <= RES_NONE;
            state_q   <= S_GATE;
          end
        end
        S_GATE: state_q <= S_UPD;
        S_UPD:  state_q <= S_DONE;
        S_DONE: begin
          if (cmd_o.res_load) state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  // A new response never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.res_load |-> (!rsp_valid_q || rsp_ready_i))
    else $error("response register overwritten");

  // At most one datapath step per cycle
  a_one_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0({cmd_o.scan_next, cmd_o.alloc_l3, cmd_o.alloc_l2, cmd_o.alloc_l1,
              cmd_o.alloc_l0, cmd_o.rd_all, cmd_o.gate, cmd_o.update,
              cmd_o.res_load}))
    else $error("more than one datapath step issued");

  // One request at a time
  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> !req_ready_o)
    else $error("request accepted while busy");

endmodule

`default_nettype wire

// ----- rtl/bpa_datapath.sv -----
// Datapath for the bitmap page allocator: page bitmap, two summary memories,
// top summary flops, index registers and the response register. Uses bpa_pkg.
`default_nettype none

module bpa_datapath
  import bpa_pkg::*;
#(
  parameter int unsigned MAP_WORDS  = 32768,
  parameter int unsigned PAGE_SHIFT = 21
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire alloc_req_t req_i,
  input  wire dp_cmd_t    cmd_i,
  output dp_sts_t         sts_o,
  output alloc_rsp_t      rsp_o
);

  // Summary hierarchy: a bit per lower-level word, set when that word is
  // non-empty. A word whose summary bit is clear reads as zero, so the
  // memories need no clearing after reset.
  localparam int unsigned L1_DEPTH   = (MAP_WORDS + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned L2_DEPTH   = (L1_DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned TOP_CHUNKS = (L2_DEPTH + WORD_BITS - 1) / WORD_BITS;
  localparam int unsigned CW  = (TOP_CHUNKS > 1) ? $clog2(TOP_CHUNKS) : 1;
  localparam int unsigned WIX_W = CW + 3 * IDX_W;  // map word index
  localparam int unsigned I1_W  = WIX_W - IDX_W;
  localparam int unsigned I2_W  = WIX_W - 2 * IDX_W;
  localparam int unsigned A0W = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int unsigned A1W = (L1_DEPTH > 1) ? $clog2(L1_DEPTH) : 1;
  localparam int unsigned A2W = (L2_DEPTH > 1) ? $clog2(L2_DEPTH) : 1;

  logic [WIX_W-1:0]     w_q, w_d;
  logic [IDX_W-1:0]     b_q, b_d;
  logic                 oor_q;
  logic [WORD_BITS-1:0] v2_q, v1_q;
  logic [WORD_BITS-1:0] m0_rd_q, m1_rd_q, m2_rd_q;
  logic [WORD_BITS-1:0] top_q [TOP_CHUNKS];
  alloc_rsp_t           rsp_q, rsp_d;

  logic [WORD_BITS-1:0] m0_mem [MAP_WORDS];
  logic [WORD_BITS-1:0] m1_mem [L1_DEPTH];
  logic [WORD_BITS-1:0] m2_mem [L2_DEPTH];

  // Index fields of the current map word
  logic [CW-1:0]    chunk;
  logic [IDX_W-1:0] b3, b2, b1;
  logic [WORD_BITS-1:0] top_word;

  assign chunk    = w_q[WIX_W-1:3*IDX_W];
  assign b3       = w_q[3*IDX_W-1:2*IDX_W];
  assign b2       = w_q[2*IDX_W-1:IDX_W];
  assign b1       = w_q[IDX_W-1:0];
  assign top_word = top_q[chunk];

  // Request address decode
  logic [ADDR_W-1:0] word_sh, page_sh;
  logic              req_oor;

  assign word_sh = req_i.address >> (PAGE_SHIFT + IDX_W);
  assign page_sh = req_i.address >> PAGE_SHIFT;
  assign req_oor = 64'(word_sh) >= 64'(MAP_WORDS);

  // Next index
  always_comb begin
    w_d = w_q;
    b_d = b_q;
    if (cmd_i.cap_req) begin
      w_d = cmd_i.scan_start ? '0 : word_sh[WIX_W-1:0];
      b_d = page_sh[IDX_W-1:0];
    end
    if (cmd_i.scan_next) w_d[WIX_W-1:3*IDX_W] = chunk + CW'(1);
    if (cmd_i.alloc_l3)  w_d[3*IDX_W-1:2*IDX_W] = find_first(top_word);
    if (cmd_i.alloc_l2)  w_d[2*IDX_W-1:IDX_W] = find_first(m2_rd_q);
    if (cmd_i.alloc_l1)  w_d[IDX_W-1:0] = find_first(m1_rd_q);
    if (cmd_i.alloc_l0)  b_d = find_first(m0_rd_q);
  end

  // Read addresses follow the next index, writes the current one
  logic [I1_W-1:0] i1_d, i1_q;
  logic [I2_W-1:0] i2_d, i2_q;
  logic            m0_re, m1_re, m2_re;

  assign i1_d  = w_d[WIX_W-1:IDX_W];
  assign i2_d  = w_d[WIX_W-1:2*IDX_W];
  assign i1_q  = w_q[WIX_W-1:IDX_W];
  assign i2_q  = w_q[WIX_W-1:2*IDX_W];
  assign m2_re = cmd_i.alloc_l3 || cmd_i.rd_all;
  assign m1_re = cmd_i.alloc_l2 || cmd_i.rd_all;
  assign m0_re = cmd_i.alloc_l1 || cmd_i.rd_all;

  // Free/mark: words behind a clear summary bit count as empty
  logic [WORD_BITS-1:0] g2, g1;

  assign g2 = top_word[b3] ? m2_rd_q : '0;
  assign g1 = g2[b2] ? m1_rd_q : '0;

  // Write-back values, propagated up the summaries
  logic [WORD_BITS-1:0] v0, mask, new0, new1, new2;
  logic                 ne2;

  always_comb begin
    v0   = v1_q[b1] ? m0_rd_q : '0;
    mask = WORD_BITS'(1) << b_q;
    new0 = cmd_i.set_bit ? (v0 | mask) : (v0 & ~mask);
    new1 = v1_q;
    new1[b1] = |new0;
    new2 = v2_q;
    new2[b2] = |new1;
    ne2  = |new2;
  end

  // Memories
  always_ff @(posedge clk_i) begin
    if (cmd_i.update) m0_mem[w_q[A0W-1:0]] <= new0;
    if (m0_re)        m0_rd_q <= m0_mem[w_d[A0W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) m1_mem[i1_q[A1W-1:0]] <= new1;
    if (m1_re)        m1_rd_q <= m1_mem[i1_d[A1W-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.update) m2_mem[i2_q[A2W-1:0]] <= new2;
    if (m2_re)        m2_rd_q <= m2_mem[i2_d[A2W-1:0]];
  end

  // Top summary, cleared at reset: all pages start used
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_q <= '{default: '0};
    end else if (cmd_i.update) begin
      top_q[chunk][b3] <= ne2;
    end
  end

  // Page address of the current index
  logic [63:0] page_full;

  assign page_full = 64'({w_q, b_q}) << PAGE_SHIFT;

  // Response value for the selected outcome
  always_comb begin
    rsp_d = '0;
    unique case (cmd_i.res_sel)
      RES_PAGE: begin
        rsp_d.page_address = page_full[ADDR_W-1:0];
        rsp_d.found        = 1'b1;
      end
      RES_OOR:  rsp_d.out_of_range = 1'b1;
      default:  ;
    endcase
  end

  // Working registers and response
  always_ff @(posedge clk_i) begin
    w_q <= w_d;
    b_q <= b_d;
    if (cmd_i.cap_req) oor_q <= req_oor;
    if (cmd_i.gate) begin
      v2_q <= g2;
      v1_q <= g1;
    end
    if (cmd_i.alloc_l2) v2_q <= m2_rd_q;
    if (cmd_i.alloc_l1) v1_q <= m1_rd_q;
    if (cmd_i.res_load) rsp_q <= rsp_d;
  end

  assign rsp_o            = rsp_q;
  assign sts_o.chunk_nz   = |top_word;
  assign sts_o.chunk_last = (chunk == CW'(TOP_CHUNKS - 1));
  assign sts_o.oor        = oor_q;

  // Allocate only descends through set summary bits, so every word it
  // reads must be non-empty
  a_l2_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_l2 |-> (m2_rd_q != '0))
    else $error("L2 summary word empty under a set top bit");

  a_l1_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_l1 |-> (m1_rd_q != '0))
    else $error("L1 summary word empty under a set L2 bit");

  a_l0_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.alloc_l0 |-> (m0_rd_q != '0))
    else $error("map word empty under a set L1 bit");

endmodule

`default_nettype wire

// ----- rtl/bitmap_page_allocator_unit.sv -----
// First-fit physical page allocator, one bit per page in a bitmap (set = free),
// every page used after reset. Requests are taken one at a time: free and
// mark-used step through read, qualify, write back and load response, and
// go from the read step straight to the response when the address lies beyond
// the map; the unused code loads its response at once. Allocate scans the
// 32-bit top summary chunks in order until one is non-empty or the last one
// is reached (a single chunk for up to 32768 map words, at most
// ceil(MAP_WORDS / 32768)). Allocate walks a three-level summary (top flops,
// two summary memories) down to the map word, one memory read per level. No
// clearing pass is needed after reset: a word whose summary bit is clear reads
// as empty. A finished response is held in an output register, so the next
// request may be taken while it waits; that request then stalls in its last
// step until the held response transfers.
// Uses bpa_pkg, bpa_ctrl and bpa_datapath.
`default_nettype none

module bitmap_page_allocator_unit
  import bpa_pkg::*;
#(
  parameter int unsigned MAP_WORDS  = 32768,
  parameter int unsigned PAGE_SHIFT = 21
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       req_valid_i,
  output logic            req_ready_o,
  input  wire alloc_req_t req_i,
  output logic            rsp_valid_o,
  input  wire logic       rsp_ready_i,
  output alloc_rsp_t      rsp_o
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  // Sequencer
  bpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_valid_i (req_valid_i),
    .req_ready_o (req_ready_o),
    .req_func_i  (req_i.func),
    .rsp_valid_o (rsp_valid_o),
    .rsp_ready_i (rsp_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  // Bitmap, summaries and response register
  bpa_datapath #(
    .MAP_WORDS  (MAP_WORDS),
    .PAGE_SHIFT (PAGE_SHIFT)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .cmd_i  (cmd),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule

`default_nettype wire

// ----- sim/tb_top.sv -----
// Self-checking testbench for bitmap_page_allocator_unit: directed and random
// allocate/free/mark-used traffic with a first-fit bitmap predictor.
// Depends on bpa_pkg and the allocator RTL.
`default_nettype none

module tb_top;
  import bpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAP_WORDS  = 32768;
  localparam int unsigned PAGE_SHIFT = 21;
  localparam int unsigned LAST_PAGE  = MAP_WORDS * WORD_BITS - 1;
  localparam int unsigned LONG_HOLD  = 400;
  localparam int unsigned DRAIN_CYC  = 20;

  logic       clk_i     = 1'b0;
  logic       rst_ni    = 1'b0;
  logic       req_valid = 1'b0;
  alloc_req_t req       = '0;
  logic       req_ready;
  logic       rsp_valid;
  logic       rsp_ready = 1'b0;
  alloc_rsp_t rsp;

  // Requests waiting to be offered, and responses the predictor says are due
  alloc_req_t  pending_reqs[$];
  alloc_rsp_t  expected_rsps[$];
  // Predicted free map: only non-empty words are held
  logic [WORD_BITS-1:0] free_words[int];

  int unsigned send_idle_pct = 0;
  int unsigned rcv_stall_pct = 0;
  logic        pressure_on   = 1'b0;
  logic        hold_started;
  int unsigned hold_left;
  int unsigned error_count   = 0;

  bitmap_page_allocator_unit #(
    .MAP_WORDS (MAP_WORDS),
    .PAGE_SHIFT(PAGE_SHIFT)
  ) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req_valid),
    .req_ready_o(req_ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp)
  );

  initial forever #6 clk_i = ~clk_i;

  // First-fit allocator: applies one request to the map, returns its response
  function automatic alloc_rsp_t allocator_step(alloc_req_t r);
    alloc_rsp_t           res;
    int                   w;
    int unsigned          b;
    longint unsigned      page;
    longint unsigned      word_idx;
    logic [WORD_BITS-1:0] word;
    res  = '0;
    page = longint'(r.address) >> PAGE_SHIFT;
    word_idx = page >> 5;
    case (func_e'(r.func))
      FUNC_ALLOC: begin
        if (free_words.first(w)) begin
          word = free_words[w];
          b = 0;
          while (!word[b]) b++;
          word[b] = 1'b0;
          if (word == '0) free_words.delete(w);
          else free_words[w] = word;
          page = (longint'(w) << 5) + b;
          res.page_address = ADDR_W'(page << PAGE_SHIFT);
          res.found = 1'b1;
        end
      end
      FUNC_FREE, FUNC_MARK: begin
        if (word_idx >= MAP_WORDS) begin
          res.out_of_range = 1'b1;
        end else begin
          w = int'(word_idx);
          word = free_words.exists(w) ? free_words[w] : '0;
          word[page[4:0]] = (func_e'(r.func) == FUNC_FREE);
          if (word == '0) free_words.delete(w);
          else free_words[w] = word;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic logic [ADDR_W-1:0] page_addr(int unsigned page,
                                                  logic [PAGE_SHIFT-1:0] low);
    return {page[ADDR_W-PAGE_SHIFT-1:0], low};
  endfunction

  task automatic push_req(func_e f, logic [ADDR_W-1:0] a);
    alloc_req_t r;
    r.func    = f;
    r.address = a;
    pending_reqs.push_back(r);
  endtask

  // Random request: pages bunch in two small windows so that allocate,
  // free and mark-used keep hitting the same words
  function automatic alloc_req_t random_request();
    alloc_req_t  r;
    int unsigned sel;
    int unsigned page;
    sel = $urandom_range(0, 99);
    if (sel < 35)      r.func = FUNC_ALLOC;
    else if (sel < 75) r.func = FUNC_FREE;
    else if (sel < 95) r.func = FUNC_MARK;
    else               r.func = FUNC_NOP;
    sel = $urandom_range(0, 99);
    if (sel < 60)      page = $urandom_range(0, 127);
    else if (sel < 75) page = LAST_PAGE - $urandom_range(0, 127);
    else               page = $urandom_range(0, LAST_PAGE);
    r.address = page_addr(page, PAGE_SHIFT'($urandom));
    return r;
  endfunction

  // Waits until every request has been taken and every response seen
  task automatic wait_drained();
    while (pending_reqs.size() != 0 || req_valid || expected_rsps.size() != 0)
      @(negedge clk_i);
  endtask

  task automatic random_phase(int unsigned n, int unsigned send_pct,
                              int unsigned rcv_pct);
    @(negedge clk_i);
    send_idle_pct = send_pct;
    rcv_stall_pct = rcv_pct;
    repeat (n) pending_reqs.push_back(random_request());
    wait_drained();
  endtask

  // Request driver: the next item is loaded once the current one transfers
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      req_valid <= 1'b0;
      req       <= '0;
    end else begin
      if (req_valid && req_ready) expected_rsps.push_back(allocator_step(req));
      if (!req_valid || req_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
          req_valid <= 1'b1;
          req       <= pending_reqs.pop_front();
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Response ready: random stalls, plus one long hold-off in the pressure phase
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_ready    <= 1'b0;
      hold_started <= 1'b0;
      hold_left    <= 0;
    end else if (pressure_on && !hold_started) begin
      hold_started <= 1'b1;
      hold_left    <= LONG_HOLD;
      rsp_ready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      rsp_ready <= 1'b0;
    end else begin
      rsp_ready <= ($urandom_range(0, 99) >= rcv_stall_pct);
    end
  end

  // Response checker
  always @(posedge clk_i) begin
    alloc_rsp_t exp_rsp;
    if (rst_ni && rsp_valid && rsp_ready) begin
      if (expected_rsps.size() == 0) begin
        $error("response transfer with none expected: %h", rsp);
        error_count++;
      end else begin
        exp_rsp = expected_rsps.pop_front();
        if (rsp.page_address !== exp_rsp.page_address) begin
          $error("page_address: expected %h, got %h", exp_rsp.page_address,
                 rsp.page_address);
          error_count++;
        end
        if (rsp.found !== exp_rsp.found) begin
          $error("found: expected %b, got %b", exp_rsp.found, rsp.found);
          error_count++;
        end
        if (rsp.out_of_range !== exp_rsp.out_of_range) begin
          $error("out_of_range: expected %b, got %b", exp_rsp.out_of_range,
                 rsp.out_of_range);
          error_count++;
        end
      end
    end
  end

  // Stimulus and end of run
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty map, edges of the address, word boundaries, no-op code
    @(negedge clk_i);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, '0);
    push_req(FUNC_FREE, '1);
    push_req(FUNC_FREE, page_addr(33, '1));
    push_req(FUNC_ALLOC, '1);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_NOP, '1);
    push_req(FUNC_FREE, page_addr(5, 21'h0AAAAA));
    push_req(FUNC_FREE, page_addr(5, 21'h155555));
    push_req(FUNC_MARK, page_addr(5, '0));
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_MARK, page_addr(7, '1));
    push_req(FUNC_FREE, page_addr(32, '0));
    push_req(FUNC_FREE, page_addr(31, '0));
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_FREE, page_addr(1 << 19, '0));
    push_req(FUNC_MARK, page_addr(LAST_PAGE, '0));
    push_req(FUNC_ALLOC, '0);
    push_req(FUNC_NOP, '0);
    wait_drained();

    random_phase(300, 0, 0);
    random_phase(200, 83, 0);
    random_phase(200, 0, 83);
    random_phase(200, 34, 34);

    // Long receiver hold-off while requests keep coming
    @(negedge clk_i);
    pressure_on = 1'b1;
    random_phase(100, 0, 0);

    random_phase(100, 0, 0);

    repeat (DRAIN_CYC) @(posedge clk_i);
    if (error_count == 0 && expected_rsps.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
